/* design/js_string_literal_escaper_core_defines.svh */
// ----------------------------------------------------------------------------
// js_string_literal_escaper_core_defines
// assertion macros shared by the escaper modules
// ----------------------------------------------------------------------------
`ifndef JS_STRING_LITERAL_ESCAPER_CORE_DEFINES_SVH
`define JS_STRING_LITERAL_ESCAPER_CORE_DEFINES_SVH

// checked only outside reset
`define JSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define JSE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/jse_pkg.sv */
// ----------------------------------------------------------------------------
// jse_pkg
// types, character codes and helpers shared by the escaper modules
// ----------------------------------------------------------------------------
package jse_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_NONE = 3'd0;
  localparam kind_t KIND_RAW  = 3'd1;
  localparam kind_t KIND_ESC2 = 3'd2;
  localparam kind_t KIND_HEX  = 3'd3;
  localparam kind_t KIND_LSEP = 3'd4;

  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_E2   = 2'd1;
  localparam logic [1:0] HELD_E280 = 2'd2;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_CTL_LIM = 8'h20;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] SEQ_B0   = 8'hE2;
  localparam logic [7:0] SEQ_B1   = 8'h80;
  localparam logic [7:0] SEQ_LS   = 8'hA8;
  localparam logic [7:0] SEQ_PS   = 8'hA9;

  localparam logic [3:0] MAX_LEN = 4'd8;

  // one classified input: released prefix, escaped body, flushed tail
  typedef struct packed {
    logic [1:0] pre_n;
    kind_t      kind;
    logic [7:0] data;
    logic [1:0] post_n;
    logic [3:0] len;
    logic       last;
  } job_t;

  function automatic logic [3:0] body_len(kind_t k);
    logic [3:0] n;
    unique case (k)
      KIND_RAW:  n = 4'd1;
      KIND_ESC2: n = 4'd2;
      KIND_HEX:  n = 4'd6;
      KIND_LSEP: n = 4'd6;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = CH_0 + {4'h0, n};
    end else begin
      c = 8'h37 + {4'h0, n};
    end
    return c;
  endfunction

endpackage

/* design/jse_front.sv */
// ----------------------------------------------------------------------------
// jse_front
// accepts input bytes, tracks the held E2 / E2 80 prefix, builds jobs
// ----------------------------------------------------------------------------
`include "js_string_literal_escaper_core_defines.svh"

module jse_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_text_last,
  input  logic           q_full,
  output logic           push,
  output jse_pkg::job_t  job
);

  logic [1:0]      held_r;
  logic [1:0]      held_nxt;
  logic            accept;
  jse_pkg::kind_t  pkind;
  logic [7:0]      pdata;
  logic            phold;
  logic [1:0]      held_mid;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // escape of one byte with nothing held
  always_comb begin
    pkind = jse_pkg::KIND_RAW;
    pdata = in_byte;
    phold = 1'b0;
    priority if (in_byte == jse_pkg::CH_BSL) begin
      pkind = jse_pkg::KIND_ESC2;
      pdata = jse_pkg::CH_BSL;
    end else if (in_byte == jse_pkg::CH_QUOTE) begin
      pkind = jse_pkg::KIND_ESC2;
      pdata = jse_pkg::CH_QUOTE;
    end else if (in_byte == jse_pkg::CH_LF) begin
      pkind = jse_pkg::KIND_ESC2;
      pdata = jse_pkg::CH_N;
    end else if (in_byte == jse_pkg::CH_CR) begin
      pkind = jse_pkg::KIND_ESC2;
      pdata = jse_pkg::CH_R;
    end else if (in_byte == jse_pkg::CH_TAB) begin
      pkind = jse_pkg::KIND_ESC2;
      pdata = jse_pkg::CH_T;
    end else if (in_byte < jse_pkg::CH_CTL_LIM || in_byte == jse_pkg::CH_LT) begin
      pkind = jse_pkg::KIND_HEX;
    end else if (in_byte == jse_pkg::SEQ_B0) begin
      pkind = jse_pkg::KIND_NONE;
      phold = 1'b1;
    end else begin
      pkind = jse_pkg::KIND_RAW;
    end
  end

  always_comb begin
    job.pre_n  = 2'd0;
    job.kind   = pkind;
    job.data   = pdata;
    job.last   = in_text_last;
    held_mid   = phold ? jse_pkg::HELD_E2 : jse_pkg::HELD_NONE;
    unique case (held_r)
      jse_pkg::HELD_E280: begin
        if (in_byte == jse_pkg::SEQ_LS || in_byte == jse_pkg::SEQ_PS) begin
          job.kind = jse_pkg::KIND_LSEP;
          job.data = (in_byte == jse_pkg::SEQ_LS) ? jse_pkg::CH_8 : jse_pkg::CH_9;
          held_mid = jse_pkg::HELD_NONE;
        end else begin
          job.pre_n = 2'd2;
        end
      end
      jse_pkg::HELD_E2: begin
        if (in_byte == jse_pkg::SEQ_B1) begin
          job.kind = jse_pkg::KIND_NONE;
          held_mid = jse_pkg::HELD_E280;
        end else begin
          job.pre_n = 2'd1;
        end
      end
      default: begin
      end
    endcase
    // end of text flushes whatever is still held
    job.post_n = in_text_last ? held_mid : 2'd0;
    held_nxt   = in_text_last ? jse_pkg::HELD_NONE : held_mid;
    job.len    = {2'b00, job.pre_n} + jse_pkg::body_len(job.kind) + {2'b00, job.post_n};
  end

  assign push = accept && (job.len != 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= jse_pkg::HELD_NONE;
    end else if (accept) begin
      held_r <= held_nxt;
    end
  end

  `JSE_ASSERT(a_held_code, held_r != 2'd3, "held prefix code out of range")
  `JSE_ASSERT(a_job_len, push |-> job.len <= jse_pkg::MAX_LEN, "job longer than eight bytes")

endmodule

/* design/jse_queue.sv */
// ----------------------------------------------------------------------------
// jse_queue
// two-entry job queue between the front and the back
// ----------------------------------------------------------------------------
`include "js_string_literal_escaper_core_defines.svh"

module jse_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jse_pkg::job_t  push_job,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output jse_pkg::job_t  head
);

  jse_pkg::job_t ent_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic [1:0]    count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign head    = ent_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  `JSE_ASSERT(a_q_count, count_r != 2'd3, "queue count out of range")
  `JSE_ASSERT(a_q_push_full, push |-> !full, "push into full queue")
  `JSE_ASSERT(a_q_pop_empty, pop |-> q_valid, "pop from empty queue")

endmodule

/* design/jse_back.sv */
// ----------------------------------------------------------------------------
// jse_back
// expands queued jobs into output bytes, one per cycle while the output is not stalled, into the output register
// ----------------------------------------------------------------------------
`include "js_string_literal_escaper_core_defines.svh"

module jse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  jse_pkg::job_t  job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_text_end
);

  logic [2:0] k_r;
  logic [2:0] k_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_run_last_r;
  logic       out_text_end_r;
  logic       load;
  logic       done;
  logic [3:0] kx;
  logic [3:0] pre;
  logic [3:0] blen;
  logic [3:0] j;
  logic [3:0] m;
  logic [7:0] body_byte;
  logic [7:0] sel_byte;

  assign load = q_valid && (!out_valid_r || out_ready);
  assign kx   = {1'b0, k_r};
  assign pre  = {2'b00, job.pre_n};
  assign blen = jse_pkg::body_len(job.kind);
  assign j    = kx - pre;
  assign m    = j - blen;
  assign done = (kx == job.len - 4'd1);

  always_comb begin
    body_byte = job.data;
    unique case (job.kind)
      jse_pkg::KIND_ESC2: begin
        body_byte = (j == 4'd0) ? jse_pkg::CH_BSL : job.data;
      end
      jse_pkg::KIND_HEX, jse_pkg::KIND_LSEP: begin
        unique case (j)
          4'd0:    body_byte = jse_pkg::CH_BSL;
          4'd1:    body_byte = jse_pkg::CH_U;
          4'd2:    body_byte = (job.kind == jse_pkg::KIND_LSEP) ? jse_pkg::CH_2 : jse_pkg::CH_0;
          4'd3:    body_byte = jse_pkg::CH_0;
          4'd4:    body_byte = (job.kind == jse_pkg::KIND_LSEP) ? jse_pkg::CH_2
                                                                : jse_pkg::hex_char(job.data[7:4]);
          default: body_byte = (job.kind == jse_pkg::KIND_LSEP) ? job.data
                                                                : jse_pkg::hex_char(job.data[3:0]);
        endcase
      end
      default: begin
        body_byte = job.data;
      end
    endcase
  end

  // prefix bytes, then the body, then the flushed tail
  always_comb begin
    priority if (kx < pre) begin
      sel_byte = (kx == 4'd0) ? jse_pkg::SEQ_B0 : jse_pkg::SEQ_B1;
    end else if (j < blen) begin
      sel_byte = body_byte;
    end else begin
      sel_byte = (m == 4'd0) ? jse_pkg::SEQ_B0 : jse_pkg::SEQ_B1;
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (load) begin
      k_nxt = done ? 3'd0 : k_r + 3'd1;
    end
  end

  assign q_pop = load && done;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r     <= sel_byte;
      out_run_last_r <= done;
      out_text_end_r <= done && job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_run_last_r;
  assign out_text_end = out_text_end_r;

  `JSE_ASSERT(a_k_in_job, q_valid |-> kx < job.len, "byte index past end of job")
  `JSE_ASSERT(a_end_on_run, (out_valid_r && out_text_end_r) |-> out_run_last_r,
              "text end without run end")

endmodule

/* design/js_string_literal_escaper_core.sv */
// ----------------------------------------------------------------------------
// js_string_literal_escaper_core
// byte-stream escaper for text placed inside a JavaScript string literal
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one raw byte (in_byte) and a flag
//   on the final byte of the text (in_text_last). output channel
//   out_valid/out_ready carries one escaped byte with out_run_last on the last
//   byte caused by an input item and out_text_end on the final byte of a text.
//   an E2 or E2 80 prefix is held inside until the following byte decides it.
// timing:
//   an input item is accepted every cycle while the two-entry job queue has
//   room; an item that only extends a held prefix produces nothing. each item
//   then expands to one to eight output bytes in the back end, so output
//   runs at one byte per cycle while the receiver takes it, and the expansion
//   is what limits input. items pass the job queue, then the output register.
// reset and stall:
//   synchronous active-low reset empties the queue, clears the held prefix and
//   drops out_valid. a stalled receiver holds the output register, the back
//   end stops, the queue fills and in_ready falls.
// ----------------------------------------------------------------------------
module js_string_literal_escaper_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_text_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;
  jse_pkg::job_t push_job;
  jse_pkg::job_t head_job;

  jse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_text_last (in_text_last),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  jse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head_job)
  );

  jse_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .job          (head_job),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

endmodule

/* verif/js_string_literal_escaper_core_tb.sv */
// ----------------------------------------------------------------------------
// js_string_literal_escaper_core_tb
// self-checking bench for the javascript string-literal escaper
// ----------------------------------------------------------------------------
// directed texts hit every escape, both line/paragraph separators, broken
// E2 80 prefixes and prefixes flushed at end of text; random texts follow,
// mostly built from escape-worthy tokens. an in-bench escaper predicts every
// output byte with its run and text flags, and a scoreboard checks the
// stream in order. both channels idle at random, with one long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module js_string_literal_escaper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS = 255;
  localparam int          CYCLE_LIMIT  = 100000;
  localparam int          HOLD_CYCLES  = 60;
  localparam logic [7:0]  ASCII_A      = 8'h41;

  localparam logic [7:0] OPENING [25] = '{
    8'h00, 8'hFF, jse_pkg::CH_BSL, jse_pkg::CH_QUOTE, jse_pkg::CH_LF, jse_pkg::CH_CR,
    jse_pkg::CH_TAB, 8'h1F, jse_pkg::CH_LT,
    jse_pkg::SEQ_B0, jse_pkg::SEQ_B1, jse_pkg::SEQ_LS, jse_pkg::SEQ_B0, jse_pkg::SEQ_B1,
    jse_pkg::SEQ_PS, jse_pkg::SEQ_B0, 8'h41,
    jse_pkg::SEQ_B0, jse_pkg::SEQ_B1, jse_pkg::CH_BSL, jse_pkg::SEQ_B0, jse_pkg::SEQ_B0,
    jse_pkg::SEQ_B1,
    jse_pkg::SEQ_B0,
    jse_pkg::CH_CTL_LIM
  };
  // final byte of each opening text
  localparam logic [24:0] OPENING_LAST = 25'h1C00100;

  localparam logic [7:0] SPECIALS [8] = '{
    jse_pkg::CH_BSL, jse_pkg::CH_QUOTE, jse_pkg::CH_LF, jse_pkg::CH_CR,
    jse_pkg::CH_TAB, jse_pkg::CH_LT, jse_pkg::SEQ_B0, jse_pkg::SEQ_B1
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } escaped_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte      = 8'h00;
  logic       in_text_last = 1'b0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_end;

  text_byte_t pending_q [$];
  escaped_t   escaped_q [$];
  logic [7:0] run_bytes [$];
  logic [1:0] held_state = jse_pkg::HELD_NONE;

  int  items_taken = 0;
  int  total_items = 0;
  int  cycle_count = 0;
  int  failures    = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  logic quiet;

  js_string_literal_escaper_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_text_last (in_text_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // stretch with no idling on either side
  assign quiet = (items_taken >= 100) && (items_taken < 170);

  function automatic logic [7:0] hex_ascii(logic [3:0] nib);
    return (nib < 4'd10) ? jse_pkg::CH_0 + 8'(nib) : ASCII_A + 8'(nib) - 8'd10;
  endfunction

  // escape one byte with nothing held; 1 means it opens a separator prefix
  function automatic bit escape_plain(logic [7:0] b);
    case (b)
      jse_pkg::CH_BSL:   run_bytes = {run_bytes, jse_pkg::CH_BSL, jse_pkg::CH_BSL};
      jse_pkg::CH_QUOTE: run_bytes = {run_bytes, jse_pkg::CH_BSL, jse_pkg::CH_QUOTE};
      jse_pkg::CH_LF:    run_bytes = {run_bytes, jse_pkg::CH_BSL, jse_pkg::CH_N};
      jse_pkg::CH_CR:    run_bytes = {run_bytes, jse_pkg::CH_BSL, jse_pkg::CH_R};
      jse_pkg::CH_TAB:   run_bytes = {run_bytes, jse_pkg::CH_BSL, jse_pkg::CH_T};
      jse_pkg::SEQ_B0:   return 1'b1;
      default: begin
        if (b < jse_pkg::CH_CTL_LIM || b == jse_pkg::CH_LT) begin
          run_bytes = {run_bytes, jse_pkg::CH_BSL, jse_pkg::CH_U, jse_pkg::CH_0,
                       jse_pkg::CH_0, hex_ascii(b[7:4]), hex_ascii(b[3:0])};
        end else begin
          run_bytes.push_back(b);
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void escape_byte(logic [7:0] b, logic last);
    logic [1:0] held;
    int n;
    held = held_state;
    run_bytes.delete();
    if (held == jse_pkg::HELD_E280) begin
      if (b == jse_pkg::SEQ_LS || b == jse_pkg::SEQ_PS) begin
        run_bytes = {run_bytes, jse_pkg::CH_BSL, jse_pkg::CH_U, jse_pkg::CH_2,
                     jse_pkg::CH_0, jse_pkg::CH_2,
                     (b == jse_pkg::SEQ_LS) ? jse_pkg::CH_8 : jse_pkg::CH_9};
        held = jse_pkg::HELD_NONE;
      end else begin
        run_bytes = {run_bytes, jse_pkg::SEQ_B0, jse_pkg::SEQ_B1};
        held = escape_plain(b) ? jse_pkg::HELD_E2 : jse_pkg::HELD_NONE;
      end
    end else if (held == jse_pkg::HELD_E2) begin
      if (b == jse_pkg::SEQ_B1) begin
        held = jse_pkg::HELD_E280;
      end else begin
        run_bytes.push_back(jse_pkg::SEQ_B0);
        held = escape_plain(b) ? jse_pkg::HELD_E2 : jse_pkg::HELD_NONE;
      end
    end else begin
      held = escape_plain(b) ? jse_pkg::HELD_E2 : jse_pkg::HELD_NONE;
    end
    // end of text flushes whatever prefix is still held
    if (last) begin
      if (held != jse_pkg::HELD_NONE) run_bytes.push_back(jse_pkg::SEQ_B0);
      if (held == jse_pkg::HELD_E280) run_bytes.push_back(jse_pkg::SEQ_B1);
      held = jse_pkg::HELD_NONE;
    end
    held_state = held;
    n = run_bytes.size();
    for (int k = 0; k < n; k++) begin
      escaped_q.push_back('{data: run_bytes[k], run_last: (k == n - 1),
                             text_end: (k == n - 1) && last});
    end
  endfunction

  function automatic void queue_text(logic [7:0] chunk [$]);
    foreach (chunk[k]) begin
      pending_q.push_back('{data: chunk[k], last: (k == chunk.size() - 1)});
    end
  endfunction

  // sender
  always @(posedge clk) begin : sender
    text_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        escape_byte(in_byte, in_text_last);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 &&
            (quiet || hold_left != 0 || $urandom_range(0, 99) >= 13)) begin
          nxt = pending_q.pop_front();
          in_valid     <= 1'b1;
          in_byte      <= nxt.data;
          in_text_last <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && items_taken >= 200) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 13);
    end
  end

  // scoreboard
  always @(posedge clk) begin : scoreboard
    escaped_t want;
    if (rst_n && out_valid && out_ready) begin
      if (escaped_q.size() == 0) begin
        $error("out_byte %h arrived with nothing expected", out_byte);
        failures++;
      end else begin
        want = escaped_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte expected %h actual %h", want.data, out_byte);
          failures++;
        end
        if (out_run_last !== want.run_last) begin
          $error("out_run_last expected %b actual %b", want.run_last, out_run_last);
          failures++;
        end
        if (out_text_end !== want.text_end) begin
          $error("out_text_end expected %b actual %b", want.text_end, out_text_end);
          failures++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [7:0] chunk [$];
    int want_len;
    int random_taken;

    foreach (OPENING[k]) begin
      pending_q.push_back('{data: OPENING[k], last: OPENING_LAST[k]});
    end

    // random texts, mostly made of escape-worthy tokens and separator prefixes
    random_taken = 0;
    while (random_taken < RANDOM_ITEMS) begin
      want_len = $urandom_range(1, 12);
      chunk.delete();
      while (chunk.size() < want_len) begin
        case ($urandom_range(0, 9))
          0: chunk = {chunk, jse_pkg::SEQ_B0, jse_pkg::SEQ_B1, jse_pkg::SEQ_LS};
          1: chunk = {chunk, jse_pkg::SEQ_B0, jse_pkg::SEQ_B1, jse_pkg::SEQ_PS};
          2: chunk = {chunk, jse_pkg::SEQ_B0, jse_pkg::SEQ_B1, 8'($urandom_range(0, 255))};
          3: chunk = {chunk, jse_pkg::SEQ_B0, 8'($urandom_range(0, 255))};
          4: chunk.push_back(SPECIALS[$urandom_range(0, 7)]);
          5: chunk.push_back(8'($urandom_range(0, 31)));
          // bare prefix, may end the text while held
          6: begin
            chunk.push_back(jse_pkg::SEQ_B0);
            if ($urandom_range(0, 1) == 0) begin
              chunk.push_back(jse_pkg::SEQ_B1);
            end
          end
          default: chunk.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      queue_text(chunk);
      random_taken += chunk.size();
    end
    total_items = pending_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (items_taken == total_items);
    while (escaped_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
